>>> rtl/thermostat_heater_cooler_controller_unit_defines.svh
// Assertion macros for the thermostat controller checker.
`ifndef THERMOSTAT_HEATER_COOLER_CONTROLLER_UNIT_DEFINES_SVH
`define THERMOSTAT_HEATER_COOLER_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during reset
`define THCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, idle during reset
`define THCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/thcc_pkg.sv
// Shared types, codes and constants of the thermostat controller.
package thcc_pkg;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_ON  = 2'd1;
	localparam logic [1:0] MODE_SET = 2'd2;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_POWER = 2'd1;
	localparam logic [1:0] KIND_UP    = 2'd2;
	localparam logic [1:0] KIND_DOWN  = 2'd3;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SAVED_TARGET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND    = 1'b1;

	localparam logic [7:0] TARGET_DEFAULT = 8'd60;
	localparam logic [7:0] TARGET_MIN     = 8'd35;
	localparam logic [7:0] TARGET_MAX     = 8'd75;
	localparam logic [7:0] TARGET_STEP    = 8'd5;
	localparam logic [4:0] BAND_DEFAULT   = 5'd5;

	typedef enum logic [2:0] {
		ST_OFF = 3'b001,
		ST_ON  = 3'b010,
		ST_SET = 3'b100
	} mode_st_t;

	typedef struct packed {
		logic       fill;
		logic       push;
		logic [7:0] data;
	} win_req_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       heater_on;
		logic       cooler_on;
		logic       heater_lamp;
		logic       display_enable;
		logic [7:0] display_value;
		logic       save_request;
		logic [7:0] save_value;
	} result_t;

	// stored target is usable only on the 5-degree grid within limits
	function automatic logic target_ok(input logic [7:0] v);
		logic ok;
		case (v) inside
			8'd35, 8'd40, 8'd45, 8'd50, 8'd55, 8'd60, 8'd65, 8'd70, 8'd75: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

>>> rtl/thcc_if.sv
// Input and result channel interfaces of the thermostat controller.
interface thcc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] temperature;

	modport source (output valid, output kind, output temperature, input ready);
	modport sink (input valid, input kind, input temperature, output ready);
endinterface

interface thcc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       heater_on;
	logic       cooler_on;
	logic       heater_lamp;
	logic       display_enable;
	logic [7:0] display_value;
	logic       save_request;
	logic [7:0] save_value;

	modport source (output valid, output mode, output heater_on, output cooler_on,
		output heater_lamp, output display_enable, output display_value,
		output save_request, output save_value, input ready);
	modport sink (input valid, input mode, input heater_on, input cooler_on,
		input heater_lamp, input display_enable, input display_value,
		input save_request, input save_value, output ready);
endinterface

>>> rtl/thcc_window.sv
// Sample window memory with per-entry valid bits, fill value and write bypass.
module thcc_window #(
	parameter int unsigned WINDOW_LEN = 10,
	localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  thcc_pkg::win_req_t win_req,
	input  logic [SLOT_W-1:0]  cur_slot,
	input  logic [SLOT_W-1:0]  next_slot,
	output logic [7:0]         old_value
);
	import thcc_pkg::*;

	logic [7:0]      mem_q [WINDOW_LEN];
	logic [7:0]      rd_s1;
	logic            byp_s1;
	logic [7:0]      byp_data_s1;
	logic [7:0]      fill_q;
	logic [WINDOW_LEN-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (win_req.push) begin
			mem_q[cur_slot] <= win_req.data;
		end
		rd_s1       <= mem_q[next_slot];
		byp_data_s1 <= win_req.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_s1 <= 1'b0;
			fill_q <= '0;
			vld_q  <= '0;
		end else begin
			byp_s1 <= win_req.push && (cur_slot == next_slot);
			if (win_req.fill) begin
				fill_q <= win_req.data;
				vld_q  <= '0;
			end else if (win_req.push) begin
				vld_q[cur_slot] <= 1'b1;
			end
		end
	end

	// entries not written since power-on read as the fill temperature
	assign old_value = byp_s1 ? byp_data_s1 : (vld_q[cur_slot] ? rd_s1 : fill_q);

endmodule

>>> rtl/thcc_ctrl.sv
// Mode, timing, target and drive logic; running window sum and average.
module thcc_ctrl #(
	parameter int unsigned WINDOW_LEN       = 10,
	parameter int unsigned TICKS_PER_SAMPLE = 10,
	parameter int unsigned TICKS_PER_SECOND = 100,
	parameter int unsigned TIMEOUT_SECONDS  = 5,
	localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [1:0]         kind,
	input  logic [7:0]         temperature,
	input  logic [7:0]         saved_target,
	input  logic [4:0]         band,
	input  logic [7:0]         old_value,
	output thcc_pkg::win_req_t win_req,
	output logic [SLOT_W-1:0]  cur_slot,
	output logic [SLOT_W-1:0]  next_slot,
	output thcc_pkg::result_t  result
);
	import thcc_pkg::*;

	localparam int unsigned DIV_SHIFT = 17;
	localparam logic [17:0] DIV_MUL = 18'(((2 ** DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

	mode_st_t    mode_q, mode_ev, mode_d;
	logic        loaded_q;
	logic [7:0]  target_q, target_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [11:0] sum_q, sum_d, sum_push;
	logic [7:0]  avg_q, avg_d, avg_push;
	logic [29:0] prod;
	logic [3:0]  smp_q, smp_d;
	logic [4:0]  smp_inc;
	logic        smp_wrap;
	logic [6:0]  sec_q, sec_d;
	logic [7:0]  sec_inc;
	logic        blink_q, blink_d;
	logic [7:0]  idle_q, idle_ev, idle_d;
	logic        heat_q, heat_d, cool_q, cool_d, lamp_q, lamp_ev, lamp_d;
	logic        heat_ev, cool_ev;
	logic        load_req;
	logic [7:0]  load_val;
	logic        save_req;
	logic [7:0]  save_val;
	logic        push_now, power_on, heating, cooling;

	// target: first-item load, then up/down steps in set mode
	always_comb begin
		target_d = target_q;
		load_req = 1'b0;
		load_val = '0;
		if (!loaded_q) begin
			if (target_ok(saved_target)) begin
				target_d = saved_target;
			end else begin
				target_d = TARGET_DEFAULT;
				load_req = 1'b1;
				load_val = TARGET_DEFAULT;
			end
		end
		if (mode_q == ST_SET) begin
			if (kind == KIND_UP && target_d < TARGET_MAX) begin
				target_d = target_d + TARGET_STEP;
			end else if (kind == KIND_DOWN && target_d > TARGET_MIN) begin
				target_d = target_d - TARGET_STEP;
			end
		end
	end

	assign smp_inc  = {1'b0, smp_q} + 5'd1;
	assign smp_wrap = smp_inc >= 5'(TICKS_PER_SAMPLE);
	assign sec_inc  = {1'b0, sec_q} + 8'd1;
	assign push_now = (kind == KIND_TICK) && (mode_q != ST_OFF) && smp_wrap;
	assign power_on = (kind == KIND_POWER) && (mode_q == ST_OFF);

	// running sum, average by reciprocal multiply (exact for sums below 4096)
	assign sum_push = sum_q - 12'(old_value) + 12'(temperature);
	assign prod     = 30'(sum_push) * 30'(DIV_MUL);
	assign avg_push = prod[DIV_SHIFT +: 8];

	always_comb begin
		sum_d  = sum_q;
		avg_d  = avg_q;
		slot_d = slot_q;
		if (power_on) begin
			sum_d = 12'(temperature) * 12'(WINDOW_LEN);
			avg_d = temperature;
		end else if (push_now) begin
			sum_d  = sum_push;
			avg_d  = avg_push;
			slot_d = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	assign heating = (9'(avg_d) + 9'(band)) < 9'(target_d);
	assign cooling = 9'(avg_d) > (9'(target_d) + 9'(band));

	// event handling
	always_comb begin
		mode_ev = mode_q;
		smp_d   = smp_q;
		sec_d   = sec_q;
		blink_d = blink_q;
		idle_ev = idle_q;
		heat_ev = heat_q;
		cool_ev = cool_q;
		lamp_ev = lamp_q;
		case (kind)
			KIND_TICK: begin
				if (mode_q != ST_OFF) begin
					smp_d = smp_wrap ? '0 : smp_inc[3:0];
					if (sec_inc >= 8'(TICKS_PER_SECOND)) begin
						sec_d   = '0;
						blink_d = !blink_q;
						if (mode_q == ST_SET && idle_q != 8'hFF) begin
							idle_ev = idle_q + 8'd1;
						end
						if (mode_q == ST_ON && heating) begin
							lamp_ev = !lamp_q;
						end
					end else begin
						sec_d = sec_inc[6:0];
					end
				end
			end
			KIND_POWER: begin
				if (mode_q == ST_OFF) begin
					mode_ev = ST_ON;
				end else begin
					mode_ev = ST_OFF;
					heat_ev = 1'b0;
					cool_ev = 1'b0;
					lamp_ev = 1'b0;
				end
			end
			default: begin
				if (mode_q == ST_ON) begin
					mode_ev = ST_SET;
					idle_ev = '0;
				end else if (mode_q == ST_SET) begin
					idle_ev = '0;
				end
			end
		endcase
	end

	// mode logic: drives in on mode, cleared in off mode, timeout in set mode
	always_comb begin
		mode_d   = mode_ev;
		idle_d   = idle_ev;
		heat_d   = heat_ev;
		cool_d   = cool_ev;
		lamp_d   = lamp_ev;
		save_req = load_req;
		save_val = load_val;
		case (mode_ev)
			ST_OFF: begin
				heat_d = 1'b0;
				cool_d = 1'b0;
				lamp_d = 1'b0;
			end
			ST_ON: begin
				if (heating) begin
					heat_d = 1'b1;
					cool_d = 1'b0;
				end else begin
					heat_d = 1'b0;
					cool_d = cooling;
					lamp_d = 1'b0;
				end
			end
			ST_SET: begin
				if (idle_ev >= 8'(TIMEOUT_SECONDS)) begin
					save_req = 1'b1;
					save_val = target_d;
					mode_d   = ST_ON;
				end
			end
			default: begin
				mode_d = ST_OFF;
			end
		endcase
	end

	always_comb begin
		result.heater_on    = heat_d;
		result.cooler_on    = cool_d;
		result.heater_lamp  = lamp_d;
		result.save_request = save_req;
		result.save_value   = save_val;
		case (mode_d)
			ST_ON: begin
				result.mode           = MODE_ON;
				result.display_enable = 1'b1;
				result.display_value  = avg_d;
			end
			ST_SET: begin
				result.mode           = MODE_SET;
				result.display_enable = blink_d;
				result.display_value  = target_d;
			end
			default: begin
				result.mode           = MODE_OFF;
				result.display_enable = 1'b0;
				result.display_value  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ST_OFF;
			loaded_q <= 1'b0;
			target_q <= TARGET_DEFAULT;
			slot_q   <= '0;
			sum_q    <= '0;
			avg_q    <= '0;
			smp_q    <= '0;
			sec_q    <= '0;
			blink_q  <= 1'b0;
			idle_q   <= '0;
			heat_q   <= 1'b0;
			cool_q   <= 1'b0;
			lamp_q   <= 1'b0;
		end else if (fire) begin
			mode_q   <= mode_d;
			loaded_q <= 1'b1;
			target_q <= target_d;
			slot_q   <= slot_d;
			sum_q    <= sum_d;
			avg_q    <= avg_d;
			smp_q    <= smp_d;
			sec_q    <= sec_d;
			blink_q  <= blink_d;
			idle_q   <= idle_d;
			heat_q   <= heat_d;
			cool_q   <= cool_d;
			lamp_q   <= lamp_d;
		end
	end

	assign win_req.fill = fire && power_on;
	assign win_req.push = fire && push_now;
	assign win_req.data = temperature;
	assign cur_slot     = slot_q;
	assign next_slot    = fire ? slot_d : slot_q;

endmodule

>>> rtl/thermostat_heater_cooler_controller_unit.sv
// Result words are registered: each is captured in the output register when its input is taken.
// Throughput: one word per cycle while the output register is not stalled; the window memory
// read at the next slot is registered, with a bypass when that slot is written in the same cycle.
// Reset: asynchronous, clears mode, counters, sum, average and drives; target resets to sixty.
// Window entries read as zero (or the power-on temperature) through valid bits; no sweep.
module thermostat_heater_cooler_controller_unit #(
	parameter int unsigned WINDOW_LEN       = 10,
	parameter int unsigned TICKS_PER_SAMPLE = 10,
	parameter int unsigned TICKS_PER_SECOND = 100,
	parameter int unsigned TIMEOUT_SECONDS  = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	thcc_in_if.sink                         in_ch,
	thcc_out_if.source                      out_ch,
	input  logic                            cfg_we,
	input  logic [thcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thcc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import thcc_pkg::*;

	localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	logic [7:0]        saved_q;
	logic [4:0]        band_q;
	logic              fire;
	logic              out_vld_q;
	result_t           result;
	result_t           res_q;
	win_req_t          win_req;
	logic [SLOT_W-1:0] cur_slot;
	logic [SLOT_W-1:0] next_slot;
	logic [7:0]        old_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_q <= TARGET_DEFAULT;
			band_q  <= BAND_DEFAULT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAVED_TARGET: saved_q <= cfg_data[7:0];
				REG_HYST_BAND:    band_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !out_vld_q || out_ch.ready;
	assign fire        = in_ch.valid && in_ch.ready;

	thcc_ctrl #(
		.WINDOW_LEN       (WINDOW_LEN),
		.TICKS_PER_SAMPLE (TICKS_PER_SAMPLE),
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.TIMEOUT_SECONDS  (TIMEOUT_SECONDS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.kind         (in_ch.kind),
		.temperature  (in_ch.temperature),
		.saved_target (saved_q),
		.band         (band_q),
		.old_value    (old_value),
		.win_req      (win_req),
		.cur_slot     (cur_slot),
		.next_slot    (next_slot),
		.result       (result)
	);

	thcc_window #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_req   (win_req),
		.cur_slot  (cur_slot),
		.next_slot (next_slot),
		.old_value (old_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= result;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.mode           = res_q.mode;
	assign out_ch.heater_on      = res_q.heater_on;
	assign out_ch.cooler_on      = res_q.cooler_on;
	assign out_ch.heater_lamp    = res_q.heater_lamp;
	assign out_ch.display_enable = res_q.display_enable;
	assign out_ch.display_value  = res_q.display_value;
	assign out_ch.save_request   = res_q.save_request;
	assign out_ch.save_value     = res_q.save_value;

endmodule

>>> rtl/thcc_checker.sv
// Port-level checks of the thermostat controller and their bind to the top level.
`include "thermostat_heater_cooler_controller_unit_defines.svh"

module thcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] mode,
	input logic       heater_on,
	input logic       cooler_on,
	input logic       heater_lamp,
	input logic       display_enable,
	input logic [7:0] display_value,
	input logic       save_request,
	input logic [7:0] save_value
);
	import thcc_pkg::*;

	`THCC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(display_value) && $stable(save_request) && $stable(save_value) && $stable(heater_on) && $stable(cooler_on), "result word changed while stalled")
	`THCC_ASSERT_NOW(a_ready_skid, in_valid || !in_valid, in_ready == (!out_valid || out_ready), "input ready does not follow output register")
	`THCC_ASSERT_NOW(a_off_dark, out_valid && (mode == MODE_OFF), !heater_on && !cooler_on && !heater_lamp && !display_enable && (display_value == 8'd0), "drive or display active while off")
	`THCC_ASSERT_NOW(a_drive_save, out_valid, !(heater_on && cooler_on) && (save_request || (save_value == 8'd0)), "heater with cooler, or stray save value")

endmodule

bind thermostat_heater_cooler_controller_unit thcc_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.mode           (out_ch.mode),
	.heater_on      (out_ch.heater_on),
	.cooler_on      (out_ch.cooler_on),
	.heater_lamp    (out_ch.heater_lamp),
	.display_enable (out_ch.display_enable),
	.display_value  (out_ch.display_value),
	.save_request   (out_ch.save_request),
	.save_value     (out_ch.save_value)
);

>>> sim/thcc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the thermostat controller: mirrors its state and checks every result word.
module thcc_scoreboard (
	input  logic                            clk,
	input  logic                            arst_n,
	thcc_in_if                              in_mon,
	thcc_out_if                             out_mon,
	input  logic                            cfg_we,
	input  logic [thcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thcc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                     mismatches,
	output int unsigned                     words_pending
);
	import thcc_pkg::*;

	localparam int WIN_LEN          = 10;
	localparam int TICKS_PER_SAMPLE = 10;
	localparam int TICKS_PER_SECOND = 100;
	localparam int TIMEOUT_SECONDS  = 5;
	localparam int IDLE_SAT         = 255;

	logic [7:0] cfg_target;
	logic [4:0] cfg_band;

	logic [1:0] th_mode;
	logic       target_taken;
	logic [7:0] target;
	logic [7:0] win_temps [WIN_LEN];
	int         win_slot;
	int         win_sum;
	logic [7:0] avg_temp;
	int         sample_ct;
	int         second_ct;
	logic       blink;
	int         idle_secs;
	logic       heat, cool, lamp;

	result_t     expected_words [$];
	int unsigned words_seen;

	function automatic logic below_band();
		return int'(avg_temp) < int'(target) - int'(cfg_band);
	endfunction

	task automatic report(input string msg);
		mismatches++;
		$display("%0t ns: %s", $time, msg);
	endtask

	task automatic compare_field(input string field, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			report($sformatf("result word %0d: %s is %0h, %0h predicted", words_seen, field, got, want));
		end
	endtask

	// one input word through the thermostat; returns the result word it causes
	task automatic thermo_step(input logic [1:0] kind, input logic [7:0] temp, output result_t w);
		w = '0;
		if (!target_taken) begin
			target_taken = 1'b1;
			if (cfg_target >= TARGET_MIN && cfg_target <= TARGET_MAX &&
				cfg_target % TARGET_STEP == 0) begin
				target = cfg_target;
			end else begin
				target = TARGET_DEFAULT;
				w.save_request = 1'b1;
				w.save_value = TARGET_DEFAULT;
			end
		end

		case (kind)
			KIND_TICK: begin
				if (th_mode != MODE_OFF) begin
					sample_ct++;
					if (sample_ct >= TICKS_PER_SAMPLE) begin
						sample_ct = 0;
						win_sum = win_sum - int'(win_temps[win_slot]) + int'(temp);
						win_temps[win_slot] = temp;
						win_slot = (win_slot + 1 >= WIN_LEN) ? 0 : win_slot + 1;
						avg_temp = 8'(win_sum / WIN_LEN);
					end
					second_ct++;
					if (second_ct >= TICKS_PER_SECOND) begin
						second_ct = 0;
						blink = ~blink;
						if (th_mode == MODE_SET && idle_secs < IDLE_SAT) idle_secs++;
						if (th_mode == MODE_ON && below_band()) lamp = ~lamp;
					end
				end
			end
			KIND_POWER: begin
				if (th_mode == MODE_OFF) begin
					th_mode = MODE_ON;
					for (int i = 0; i < WIN_LEN; i++) win_temps[i] = temp;
					win_sum = int'(temp) * WIN_LEN;
					avg_temp = temp;
				end else begin
					th_mode = MODE_OFF;
					{heat, cool, lamp} = '0;
				end
			end
			default: begin
				if (th_mode == MODE_ON) begin
					th_mode = MODE_SET;
					idle_secs = 0;
				end else if (th_mode == MODE_SET) begin
					if (kind == KIND_UP && target < TARGET_MAX) target = target + TARGET_STEP;
					else if (kind == KIND_DOWN && target > TARGET_MIN) target = target - TARGET_STEP;
					idle_secs = 0;
				end
			end
		endcase

		if (th_mode == MODE_OFF) begin
			{heat, cool, lamp} = '0;
		end else if (th_mode == MODE_ON) begin
			if (below_band()) begin
				heat = 1'b1;
				cool = 1'b0;
			end else if (int'(avg_temp) > int'(target) + int'(cfg_band)) begin
				{heat, cool, lamp} = 3'b010;
			end else begin
				{heat, cool, lamp} = '0;
			end
		end else if (idle_secs >= TIMEOUT_SECONDS) begin
			// drives are left alone until the next word
			w.save_request = 1'b1;
			w.save_value = target;
			th_mode = MODE_ON;
		end

		w.mode = th_mode;
		w.heater_on = heat;
		w.cooler_on = cool;
		w.heater_lamp = lamp;
		if (th_mode == MODE_ON) begin
			w.display_enable = 1'b1;
			w.display_value = avg_temp;
		end else if (th_mode == MODE_SET) begin
			w.display_enable = blink;
			w.display_value = target;
		end
	endtask

	task automatic check_word(input result_t want);
		compare_field("mode", 8'(out_mon.mode), 8'(want.mode));
		compare_field("heater_on", 8'(out_mon.heater_on), 8'(want.heater_on));
		compare_field("cooler_on", 8'(out_mon.cooler_on), 8'(want.cooler_on));
		compare_field("heater_lamp", 8'(out_mon.heater_lamp), 8'(want.heater_lamp));
		compare_field("display_enable", 8'(out_mon.display_enable), 8'(want.display_enable));
		compare_field("display_value", out_mon.display_value, want.display_value);
		compare_field("save_request", 8'(out_mon.save_request), 8'(want.save_request));
		compare_field("save_value", out_mon.save_value, want.save_value);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			cfg_target = TARGET_DEFAULT;
			cfg_band = BAND_DEFAULT;
			th_mode = MODE_OFF;
			target_taken = 1'b0;
			target = TARGET_DEFAULT;
			for (int i = 0; i < WIN_LEN; i++) win_temps[i] = '0;
			win_slot = 0;
			win_sum = 0;
			avg_temp = '0;
			sample_ct = 0;
			second_ct = 0;
			blink = 1'b0;
			idle_secs = 0;
			{heat, cool, lamp} = '0;
			expected_words.delete();
			words_seen = 0;
			mismatches = 0;
			words_pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SAVED_TARGET: cfg_target = cfg_data[7:0];
					REG_HYST_BAND:    cfg_band = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				thermo_step(in_mon.kind, in_mon.temperature, w);
				expected_words.push_back(w);
			end
			if (out_mon.valid && out_mon.ready) begin
				if (expected_words.size() == 0) begin
					report($sformatf("result word %0d arrived with nothing predicted", words_seen));
				end else begin
					check_word(expected_words.pop_front());
				end
				words_seen++;
			end
			words_pending <= $unsigned(expected_words.size());
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the thermostat controller: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
	import thcc_pkg::*;

	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int SINK_HOLD_CYCLES = 60;
	localparam int PHASES           = 8;
	localparam int WORDS_PER_PHASE  = 40;
	localparam int IDLE_PERCENT     = 9;
	localparam int SETTLE_CYCLES    = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           mismatches;
	int unsigned           words_pending;

	bit         calm = 1'b0;
	int         holds_wanted = 0;
	int         holds_done = 0;
	int         stall_cycles = 0;
	int         words_sent = 0;
	logic [7:0] room_temp = 8'd60;

	thcc_in_if  in_ch ();
	thcc_out_if out_ch ();

	thermostat_heater_cooler_controller_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	thcc_scoreboard u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.words_pending (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// slow drift around the set range, with the odd jump across the full scale
	function automatic logic [7:0] drift_temp();
		int r, t;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			room_temp = 8'($urandom_range(0, 255));
		end else if (r < 8) begin
			room_temp = 8'($urandom_range(10, 110));
		end else begin
			t = int'(room_temp) + int'($urandom_range(0, 6)) - 3;
			room_temp = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
		end
		return room_temp;
	endfunction

	task automatic send_word(input logic [1:0] kind, input logic [7:0] temp);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.temperature <= temp;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
	endtask

	task automatic tick_burst(input int n);
		repeat (n) send_word(KIND_TICK, drift_temp());
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	task automatic write_regs(input logic [7:0] saved, input logic [4:0] band);
		cfg_we <= 1'b1;
		cfg_index <= REG_SAVED_TARGET;
		cfg_data <= CFG_DATA_W'(saved);
		@(posedge clk);
		cfg_index <= REG_HYST_BAND;
		cfg_data <= CFG_DATA_W'(band);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_step();
		int pick, n;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			send_word(KIND_POWER, drift_temp());
		end else if (pick < 20) begin
			// enter set mode, adjust, then a few ticks
			n = $urandom_range(1, 5);
			repeat (n) begin
				send_word($urandom_range(0, 1) ? KIND_UP : KIND_DOWN, drift_temp());
				tick_burst($urandom_range(0, 3));
			end
			tick_burst($urandom_range(1, 40));
		end else if (pick < 30) begin
			send_word($urandom_range(0, 1) ? KIND_UP : KIND_DOWN, drift_temp());
		end else if (pick < 40) begin
			tick_burst($urandom_range(90, 110));
		end else begin
			tick_burst($urandom_range(1, 12));
		end
	endtask

	initial begin
		int v, phase_end;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= KIND_TICK;
		in_ch.temperature <= 8'd0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SAVED_TARGET;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stored target off the grid, so the first word falls back to sixty
		v = $urandom_range(0, 255);
		if (v >= 35 && v <= 75 && v % 5 == 0) v++;
		write_regs(8'(v), 5'd3);

		send_word(KIND_TICK, 8'd255);
		send_word(KIND_UP, 8'd0);
		send_word(KIND_DOWN, 8'd0);
		send_word(KIND_POWER, 8'd20);
		send_word(KIND_TICK, 8'd20);
		send_word(KIND_UP, 8'd20);
		repeat (4) send_word(KIND_UP, 8'd20);
		repeat (9) send_word(KIND_DOWN, 8'd20);
		send_word(KIND_POWER, 8'd20);
		send_word(KIND_POWER, 8'd200);
		send_word(KIND_POWER, 8'd0);
		send_word(KIND_POWER, 8'd255);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase % 4)
				0: write_regs(8'd0, 5'd0);
				1: write_regs(8'd255, 5'd30);
				default: write_regs(8'($urandom_range(0, 255)), 5'($urandom_range(0, 30)));
			endcase
			calm = (phase == 1);
			if (phase % 4 == 2) holds_wanted++;
			phase_end = words_sent + WORDS_PER_PHASE;
			while (words_sent < phase_end) random_step();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && words_pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// result side: random back-pressure, plus long hold-offs on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < holds_wanted) begin
				holds_done++;
				out_ch.ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
